[rtl/sensor_response_frame_checker_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sensor response frame checker
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SENSOR_RESPONSE_FRAME_CHECKER_ASSERT_SVH
`define SENSOR_RESPONSE_FRAME_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRFC_ASSERT_SAME(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("srfc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRFC_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("srfc: next-cycle check failed");

`endif

[rtl/srfc_pkg.sv]
// ----------------------------------------------------------------------------
// Sensor response frame checker package
// Shared constants, status codes and the bytewise CRC-16 update.
// ----------------------------------------------------------------------------
package srfc_pkg;

  localparam int RxByteW   = 8;
  localparam int ValueW    = 16;
  localparam int OutDataW  = 40;
  localparam int PosW      = 3;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  FUNC_READ = 8'h03;
  localparam logic [7:0]  REG_COUNT = 8'h04;

  localparam logic [PosW-1:0] POS_FUNC     = 3'd0;
  localparam logic [PosW-1:0] POS_COUNT    = 3'd1;
  localparam logic [PosW-1:0] POS_HUM_HI   = 3'd2;
  localparam logic [PosW-1:0] POS_HUM_LO   = 3'd3;
  localparam logic [PosW-1:0] POS_TEMP_HI  = 3'd4;
  localparam logic [PosW-1:0] POS_TEMP_LO  = 3'd5;
  localparam logic [PosW-1:0] POS_CRC_LO   = 3'd6;
  localparam logic [PosW-1:0] POS_CRC_HI   = 3'd7;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_HEADER = 2'd1,
    STATUS_CRC    = 2'd2
  } status_t;

  // Reflected CRC-16 update over one byte, least significant bit first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/sensor_response_frame_checker.sv]
// ----------------------------------------------------------------------------
// Sensor response frame checker
// Checks an eight-byte sensor read reply (header and CRC-16) and gives
// humidity and signed temperature in tenths on the last byte.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] rx_byte, tuser frame_start
// m_axis    out        tdata[1:0] status, [17:2] humidity, [33:18] temperature
//
// One byte is accepted per cycle while no result is stalled; each byte is held
// in the input register and is then folded into the frame state in a single pass.
// A result is registered in the output stage once the last byte leaves the input register.
// Reset is synchronous and clears both stages and the frame position.
// A stalled result blocks only the next last byte; other bytes keep flowing.
// ----------------------------------------------------------------------------
module sensor_response_frame_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [srfc_pkg::RxByteW-1:0]     s_axis_tdata,  // [7:0] rx_byte
  input  logic                             s_axis_tuser,  // [0] frame_start
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] status, [17:2] humidity_tenths, [33:18] temperature_tenths,
  // [39:34] zero
  output logic [srfc_pkg::OutDataW-1:0]    m_axis_tdata
);
  import srfc_pkg::*;

  logic                in_valid;
  logic [RxByteW-1:0]  in_byte;
  logic                in_start;

  logic [PosW-1:0]     byte_position;
  logic [15:0]         running_crc;
  logic                header_bad;
  logic [ValueW-1:0]   humidity_hold;
  logic [ValueW-1:0]   temperature_hold;
  logic [7:0]          crc_low_hold;

  logic                out_valid;
  status_t             out_status;
  logic [ValueW-1:0]   out_humidity;
  logic [ValueW-1:0]   out_temperature;

  logic [PosW-1:0]     pos;
  logic [15:0]         crc_cur;
  logic                header_cur;
  logic [15:0]         crc_upd;
  logic                last_byte;
  logic                advance;
  logic                s_accept;

  logic [PosW-1:0]     byte_position_next;
  logic [15:0]         running_crc_next;
  logic                header_bad_next;

  status_t             status_next;
  logic [ValueW-1:0]   humidity_next;
  logic [ValueW-1:0]   temperature_next;
  logic [15:0]         crc_got;
  logic [ValueW-1:0]   temp_mag;

  assign pos        = in_start ? POS_FUNC : byte_position;
  assign crc_cur    = in_start ? CRC_INIT : running_crc;
  assign header_cur = in_start ? 1'b0 : header_bad;
  assign crc_upd    = crc16_byte(crc_cur, in_byte);
  assign last_byte  = (pos == POS_CRC_HI);

  assign advance       = in_valid && (!last_byte || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign crc_got  = {in_byte, crc_low_hold};
  assign temp_mag = {1'b0, temperature_hold[ValueW-2:0]};

  always_comb begin
    byte_position_next = pos + 3'd1;
    running_crc_next   = crc_cur;
    header_bad_next    = header_cur;
    case (pos)
      POS_FUNC: begin
        running_crc_next = crc_upd;
        header_bad_next  = (in_byte != FUNC_READ);
      end
      POS_COUNT: begin
        running_crc_next = crc_upd;
        header_bad_next  = header_cur || (in_byte != REG_COUNT);
      end
      POS_HUM_HI, POS_HUM_LO, POS_TEMP_HI, POS_TEMP_LO: begin
        running_crc_next = crc_upd;
      end
      POS_CRC_HI: begin
        byte_position_next = POS_FUNC;
        running_crc_next   = CRC_INIT;
        header_bad_next    = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status_next      = STATUS_OK;
    humidity_next    = '0;
    temperature_next = '0;
    if (header_cur) begin
      status_next = STATUS_HEADER;
    end else if (crc_got != crc_cur) begin
      status_next = STATUS_CRC;
    end else begin
      humidity_next    = humidity_hold;
      temperature_next = temperature_hold[ValueW-1] ? (~temp_mag + 16'd1) : temp_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_FUNC;
      running_crc   <= CRC_INIT;
      header_bad    <= 1'b0;
    end else if (advance) begin
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      header_bad    <= header_bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      case (pos)
        POS_HUM_HI:  humidity_hold[15:8]    <= in_byte;
        POS_HUM_LO:  humidity_hold[7:0]     <= in_byte;
        POS_TEMP_HI: temperature_hold[15:8] <= in_byte;
        POS_TEMP_LO: temperature_hold[7:0]  <= in_byte;
        POS_CRC_LO:  crc_low_hold           <= in_byte;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && last_byte) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_byte) begin
      out_status      <= status_next;
      out_humidity    <= humidity_next;
      out_temperature <= temperature_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b000000, out_temperature, out_humidity, out_status};

endmodule

[rtl/srfc_port_checker.sv]
// ----------------------------------------------------------------------------
// Sensor response frame checker port assertions
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
`include "sensor_response_frame_checker_assert.svh"

module srfc_port_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [srfc_pkg::RxByteW-1:0]     s_axis_tdata,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [srfc_pkg::OutDataW-1:0]    m_axis_tdata
);
  import srfc_pkg::*;

  logic in_seen;
  logic out_stall;
  logic out_err;
  logic out_legal;

  assign in_seen   = s_axis_tvalid || s_axis_tready || s_axis_tuser || (|s_axis_tdata);
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_err   = m_axis_tvalid && (m_axis_tdata[1:0] != STATUS_OK);
  assign out_legal = (m_axis_tdata[1:0] <= STATUS_CRC) && (m_axis_tdata[OutDataW-1:34] == '0);

  `SRFC_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
  `SRFC_ASSERT_SAME(a_status_code, clk, rst, m_axis_tvalid, out_legal)
  `SRFC_ASSERT_SAME(a_err_zero, clk, rst, out_err, m_axis_tdata[33:2] == 32'd0)
  `SRFC_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst || (!in_seen && rst), !m_axis_tvalid)

endmodule

bind sensor_response_frame_checker srfc_port_checker u_srfc_port_checker (.*);

[tb/reply_result_monitor.sv]
// ----------------------------------------------------------------------------
// Reply result monitor
// Watches both stream channels of the sensor response frame checker. It folds
// every accepted reply byte into its own frame state and queues the reading
// that each completed frame should produce. It then compares every result
// transaction with the oldest queued reading, field by field.
// ----------------------------------------------------------------------------
package reply_frame_tb_pkg;

  typedef struct {
    srfc_pkg::status_t  status;
    logic [15:0]        humidity;
    logic signed [15:0] temperature;
  } reading_t;

  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        feedback;
    acc = crc;
    for (int k = 0; k < 8; k++) begin
      feedback = acc[0] ^ b[k];
      acc = acc >> 1;
      if (feedback) begin
        acc = acc ^ srfc_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

endpackage

module reply_result_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [srfc_pkg::RxByteW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [srfc_pkg::OutDataW-1:0] m_axis_tdata,
  output int                            error_count,
  output int                            pending,
  output int                            ok_frames,
  output int                            header_frames,
  output int                            crc_frames
);
  import srfc_pkg::*;
  import reply_frame_tb_pkg::*;

  logic [PosW-1:0] frame_pos;
  logic [15:0]     crc_acc;
  logic            hdr_fail;
  logic [15:0]     hum_word;
  logic [15:0]     temp_word;
  logic [7:0]      crc_lo;
  reading_t        awaited_readings[$];

  initial begin
    error_count = 0;
    pending = 0;
    ok_frames = 0;
    header_frames = 0;
    crc_frames = 0;
  end

  task automatic restart_frame();
    frame_pos = POS_FUNC;
    crc_acc = CRC_INIT;
    hdr_fail = 1'b0;
  endtask

  task automatic fold_reply_byte(input logic [7:0] b, input logic start);
    reading_t    r;
    logic [14:0] mag;
    if (start) begin
      restart_frame();
    end
    if (frame_pos <= POS_TEMP_LO) begin
      crc_acc = crc16_fold(crc_acc, b);
    end
    case (frame_pos)
      POS_FUNC: hdr_fail = (b != FUNC_READ);
      POS_COUNT: begin
        if (b != REG_COUNT) begin
          hdr_fail = 1'b1;
        end
      end
      POS_HUM_HI:  hum_word[15:8] = b;
      POS_HUM_LO:  hum_word[7:0] = b;
      POS_TEMP_HI: temp_word[15:8] = b;
      POS_TEMP_LO: temp_word[7:0] = b;
      POS_CRC_LO:  crc_lo = b;
      default: ;
    endcase
    if (frame_pos != POS_CRC_HI) begin
      frame_pos = frame_pos + 1'b1;
    end else begin
      r.humidity = '0;
      r.temperature = '0;
      if (hdr_fail) begin
        r.status = STATUS_HEADER;
        header_frames++;
      end else if ({b, crc_lo} != crc_acc) begin
        r.status = STATUS_CRC;
        crc_frames++;
      end else begin
        r.status = STATUS_OK;
        r.humidity = hum_word;
        mag = temp_word[14:0];
        r.temperature = temp_word[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        ok_frames++;
      end
      awaited_readings.push_back(r);
      restart_frame();
    end
  endtask

  task automatic check_result(input logic [OutDataW-1:0] d);
    reading_t r;
    if (awaited_readings.size() == 0) begin
      $error("result transaction with no reading awaited: tdata %h", d);
      error_count++;
    end else begin
      r = awaited_readings.pop_front();
      if (d[1:0] !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, d[1:0]);
        error_count++;
      end
      if (d[17:2] !== r.humidity) begin
        $error("humidity_tenths: expected %0d, got %0d", r.humidity, d[17:2]);
        error_count++;
      end
      if (d[33:18] !== r.temperature) begin
        $error("temperature_tenths: expected %0d, got %0d", r.temperature,
               $signed(d[33:18]));
        error_count++;
      end
      if (d[OutDataW-1:34] !== '0) begin
        $error("tdata padding: expected 0, got %h", d[OutDataW-1:34]);
        error_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_frame();
      awaited_readings.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fold_reply_byte(s_axis_tdata, s_axis_tuser);
      end
    end
    pending = awaited_readings.size();
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Sensor response frame checker testbench
// Feeds directed and random reply frames, broken frames and noise bytes into
// the block with random idling on both channels. A separate monitor predicts
// and checks every result.
// ----------------------------------------------------------------------------
module tb;
  import srfc_pkg::*;
  import reply_frame_tb_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [RxByteW-1:0]   s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;

  int error_count;
  int pending;
  int ok_frames;
  int header_frames;
  int crc_frames;
  int bytes_sent = 0;
  bit sender_quiet = 1'b0;
  bit receiver_quiet = 1'b0;
  bit hold_request = 1'b0;

  sensor_response_frame_checker dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  reply_result_monitor u_reply_monitor (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .error_count   (error_count),
    .pending       (pending),
    .ok_frames     (ok_frames),
    .header_frames (header_frames),
    .crc_frames    (crc_frames)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (60) @(posedge clk);
      end else begin
        m_axis_tready <= receiver_quiet || ($urandom_range(99) >= 32);
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    while (!sender_quiet && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= start;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends the first byte_count bytes of a reply; crc_flip corrupts the trailer.
  task automatic send_frame(input logic [7:0] fc, input logic [7:0] cnt,
                            input logic [15:0] hum, input logic [15:0] temp,
                            input logic [15:0] crc_flip, input logic start,
                            input int byte_count);
    logic [7:0]  frame_bytes[8];
    logic [15:0] crc;
    frame_bytes[0] = fc;
    frame_bytes[1] = cnt;
    frame_bytes[2] = hum[15:8];
    frame_bytes[3] = hum[7:0];
    frame_bytes[4] = temp[15:8];
    frame_bytes[5] = temp[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc = crc16_fold(crc, frame_bytes[i]);
    end
    crc = crc ^ crc_flip;
    frame_bytes[6] = crc[7:0];
    frame_bytes[7] = crc[15:8];
    for (int i = 0; i < byte_count; i++) begin
      send_byte(frame_bytes[i], (i == 0) ? start : 1'b0);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  function automatic logic [15:0] pick_temp();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_hum();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int         frame_no;
    int         kind;
    bit         aligned;
    logic [7:0] fc;
    logic [7:0] cnt;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Negative zero temperature, then a back-to-back frame without a start mark.
    send_frame(FUNC_READ, REG_COUNT, 16'hFFFF, 16'h8000, 16'h0000, 1'b1, 8);
    send_frame(FUNC_READ, REG_COUNT, 16'h0000, 16'h7FFF, 16'h0000, 1'b0, 8);
    // A frame cut short by a new start, then full negative magnitude.
    send_frame(FUNC_READ, REG_COUNT, 16'h1234, 16'h0100, 16'h0000, 1'b1, 2);
    send_frame(FUNC_READ, REG_COUNT, 16'h03E8, 16'hFFFF, 16'h0000, 1'b1, 8);
    // Bad header and bad CRC together must report the header.
    send_frame(8'h00, 8'hFF, 16'h5A5A, 16'h00FF, 16'hFFFF, 1'b0, 8);
    wait_drained();

    frame_no = 0;
    aligned = 1'b1;
    while (bytes_sent < 640) begin
      if (frame_no == 25) begin
        hold_request = 1'b1;
        sender_quiet = 1'b1;
      end
      if (frame_no == 30) begin
        sender_quiet = 1'b0;
      end
      if (frame_no == 45) begin
        sender_quiet = 1'b1;
        receiver_quiet = 1'b1;
      end
      if (frame_no == 60) begin
        sender_quiet = 1'b0;
        receiver_quiet = 1'b0;
      end
      if (frame_no == 70) begin
        wait_drained();
      end
      kind = $urandom_range(99);
      fc = FUNC_READ;
      cnt = REG_COUNT;
      if (kind >= 70 && kind < 78) begin
        if ($urandom_range(2) != 0) fc = FUNC_READ ^ 8'($urandom_range(1, 255));
        if ($urandom_range(2) != 1) cnt = REG_COUNT ^ 8'($urandom_range(1, 255));
      end
      if (kind >= 88) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom_range(1)));
        aligned = 1'b0;
      end else if (kind >= 78) begin
        send_frame(fc, cnt, pick_hum(), pick_temp(), 16'h0000, 1'b1, $urandom_range(1, 7));
        aligned = 1'b0;
      end else begin
        send_frame(fc, cnt, pick_hum(), pick_temp(),
                   (kind >= 60 && kind < 70) ? 16'($urandom_range(1, 65535)) : 16'h0000,
                   !aligned || ($urandom_range(1) == 1), 8);
        aligned = 1'b1;
      end
      frame_no++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d reply bytes in %0d random sequences after the directed frames.",
             bytes_sent, frame_no);
    $display("Results seen: %0d good, %0d header mismatch, %0d CRC mismatch.",
             ok_frames, header_frames, crc_frames);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
